// ===== sv/scst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scst_pkg;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 18;
  localparam int WIDE_W = 33;
  localparam int WRAP_W = 28;
  localparam int MAG_W = 25;
  localparam int QUOT_W = 6;

  // angle constants, radians scaled by 2^24
  localparam logic [26:0] ANG_PI = 27'd52707179;
  localparam logic [26:0] ANG_HALF_PI = 27'd26353589;
  localparam logic [26:0] ANG_TWO_PI = 27'd105414358;

  // reciprocal of two pi for the turn count estimate
  localparam int WRAP_SHIFT = 40;
  localparam int WRAP_RECIP_W = 14;
  localparam logic [WRAP_RECIP_W-1:0] WRAP_RECIP =
    WRAP_RECIP_W'((64'd1 << WRAP_SHIFT) / 64'd105414358);

  localparam int IDX_SHIFT = 40;
  localparam logic [VALUE_W-1:0] ONE_Q16 = 18'd65536;

  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] SIN_DIV [16] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
  };
  localparam logic [63:0] COS_DIV [16] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
    64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992
  };

  typedef enum logic [1:0] {
    CLS_INSIDE,
    CLS_ABOVE,
    CLS_BELOW
  } range_cls_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] x;
    logic [ANGLE_W-1:0]       v;
    range_cls_t               cls;
  } scst_item_t;

  // unsigned q2.62 product, truncated
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  function automatic logic [63:0] quantize(input logic [63:0] v, input int cw);
    logic [63:0] r;
    logic [63:0] lim;
    r = (v + (64'd1 << (61 - cw))) >> (62 - cw);
    lim = (64'd1 << cw) - 64'd1;
    return (r > lim) ? lim : r;
  endfunction

  // least-squares line of sin over one segment: {slope, offset}
  function automatic logic [63:0] rom_entry(input logic [63:0] idx, input logic [63:0] d,
                                            input int cw);
    logic [63:0] c, d2, d4, sd, qd, c2, ss, cc, t, u, k, m, mc, slope, offset;
    c = d * (64'd2 * idx + 64'd1);
    d2 = mulq(d, d);
    d4 = mulq(d2, d2);
    sd = ONE_Q62 - d2 / 64'd6 + d4 / 64'd120;
    qd = ONE_Q62 - d2 / 64'd10 + d4 / 64'd280;
    c2 = mulq(c, c);
    ss = c;
    cc = ONE_Q62;
    t = c;
    u = ONE_Q62;
    for (int i = 0; i < 16; i++) begin
      t = mulq(t, c2) / SIN_DIV[i];
      u = mulq(u, c2) / COS_DIV[i];
      if (i[0] == 1'b0) begin
        ss = ss - t;
        cc = cc - u;
      end else begin
        ss = ss + t;
        cc = cc + u;
      end
    end
    k = mulq(ss, sd);
    m = mulq(cc, qd);
    mc = mulq(m, c);
    slope = quantize(m, cw);
    offset = quantize((k > mc) ? (k - mc) : 64'd0, cw);
    return {slope[31:0], offset[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== sv/scst_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scst_front
  import scst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               mode,
  input  wire logic signed [31:0] angle,
  input  wire logic               q_full,
  output logic                    busy,
  output logic                    push,
  output scst_item_t              item
);

  localparam logic signed [WIDE_W-1:0] PI_S = $signed(WIDE_W'(ANG_PI));
  localparam logic signed [WIDE_W-1:0] HALF_PI_S = $signed(WIDE_W'(ANG_HALF_PI));

  logic                     held;
  logic                     held_next;
  logic                     accept;
  logic signed [WIDE_W-1:0] ang_ext;
  logic signed [WIDE_W-1:0] x_in;
  scst_item_t               item_in;

  assign busy = held && q_full;
  assign accept = start && !busy;
  assign push = held && !q_full;
  assign held_next = accept || (held && q_full);

  always_comb begin
    ang_ext = $signed({angle[ANGLE_W-1], angle});
    // cosine is the sine of the complement
    x_in = mode ? (HALF_PI_S - ang_ext) : ang_ext;
    item_in.x = x_in;
    if (x_in > PI_S) begin
      item_in.cls = CLS_ABOVE;
      item_in.v = ANGLE_W'(x_in + PI_S);
    end else if (x_in < -PI_S) begin
      item_in.cls = CLS_BELOW;
      item_in.v = ANGLE_W'(PI_S - x_in);
    end else begin
      item_in.cls = CLS_INSIDE;
      item_in.v = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/scst_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scst_queue
  import scst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire scst_item_t  din,
  input  wire logic        pop,
  output scst_item_t       dout,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  scst_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/scst_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scst_back
  import scst_pkg::*;
#(
  parameter int TABLE_SEGMENTS = 128,
  parameter int COEFF_WIDTH = 18
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire scst_item_t        in_item,
  output logic                   strobe,
  output logic signed [17:0]     value
);

  localparam int IW = $clog2(TABLE_SEGMENTS);
  localparam int STAGES = 10;
  localparam logic [63:0] SEG_HALF_W = PI_Q62 / 64'(4 * TABLE_SEGMENTS);
  localparam logic [63:0] IDX_RECIP = (64'(TABLE_SEGMENTS) << IDX_SHIFT) / 64'(ANG_HALF_PI);
  localparam int IDX_PROD_W = IDX_SHIFT + IW + 1;
  localparam int SEGP_W = MAG_W + IW + 1;
  localparam int SUM_W = COEFF_WIDTH + 26;
  localparam int RSH = COEFF_WIDTH + 8;
  localparam int VAL_W = SUM_W - RSH;

  logic [STAGES:1] vld;

  // stage 1: turn count estimate
  logic [ANGLE_W-1:0]          v1;
  logic signed [WIDE_W-1:0]    x1;
  range_cls_t                  cls1;
  logic [QUOT_W-1:0]           q1;
  logic [ANGLE_W+WRAP_RECIP_W-1:0] wrap_prod;
  // stage 2: remainder before correction
  logic [WRAP_W-1:0]           r2;
  logic signed [WIDE_W-1:0]    x2;
  range_cls_t                  cls2;
  logic [WIDE_W-1:0]           r_full;
  // stage 3: wrapped angle
  logic [WRAP_W-1:0]           r_mod;
  logic signed [WRAP_W-1:0]    xw_next;
  logic signed [WRAP_W-1:0]    xw3;
  // stage 4: sign and folded magnitude
  logic [WRAP_W-1:0]           mag;
  logic [MAG_W-1:0]            fold_next;
  logic                        neg4;
  logic [MAG_W-1:0]            m4;
  logic                        quarter4;
  // stage 5: segment estimate
  logic [IDX_PROD_W-1:0]       idx_prod;
  logic [IW:0]                 est5;
  logic [SEGP_W-1:0]           segp5;
  logic                        neg5;
  logic [MAG_W-1:0]            m5;
  logic                        quarter5;
  // stage 6: estimate remainder
  logic [SEGP_W-1:0]           rem6;
  logic [IW:0]                 est6;
  logic                        neg6;
  logic [MAG_W-1:0]            m6;
  logic                        quarter6;
  // stage 7: final segment
  logic [IW:0]                 idx_fix;
  logic [IW-1:0]               idx7;
  logic                        neg7;
  logic [MAG_W-1:0]            m7;
  logic                        quarter7;
  // stage 8: coefficients
  logic [COEFF_WIDTH-1:0]      slope8;
  logic [COEFF_WIDTH-1:0]      offset8;
  logic                        neg8;
  logic [MAG_W-1:0]            m8;
  logic                        quarter8;
  // stage 9: linear term
  logic [SUM_W-1:0]            sum9;
  logic                        neg9;
  logic                        quarter9;
  // stage 10: output
  logic [SUM_W-1:0]            rounded;
  logic [VAL_W-1:0]            val_raw;
  logic [VALUE_W-1:0]          val_mag;
  logic signed [VALUE_W-1:0]   value_next;

  logic [COEFF_WIDTH-1:0] slope_rom  [TABLE_SEGMENTS];
  logic [COEFF_WIDTH-1:0] offset_rom [TABLE_SEGMENTS];

  for (genvar g = 0; g < TABLE_SEGMENTS; g++) begin : g_rom
    localparam logic [63:0] ENTRY = rom_entry(64'(g), SEG_HALF_W, COEFF_WIDTH);
    assign slope_rom[g] = ENTRY[32 +: COEFF_WIDTH];
    assign offset_rom[g] = ENTRY[0 +: COEFF_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-1:1], in_valid};
    end
  end

  assign strobe = vld[STAGES];

  always_comb begin
    wrap_prod = (ANGLE_W + WRAP_RECIP_W)'(in_item.v) * (ANGLE_W + WRAP_RECIP_W)'(WRAP_RECIP);
    r_full = WIDE_W'(v1) - WIDE_W'(q1) * WIDE_W'(ANG_TWO_PI);

    // estimate is low by at most one turn
    r_mod = (r2 >= WRAP_W'(ANG_TWO_PI)) ? (r2 - WRAP_W'(ANG_TWO_PI)) : r2;
    unique case (cls2)
      CLS_ABOVE: xw_next = $signed(r_mod) - $signed(WRAP_W'(ANG_PI));
      CLS_BELOW: xw_next = $signed(WRAP_W'(ANG_PI)) - $signed(r_mod);
      CLS_INSIDE: xw_next = x2[WRAP_W-1:0];
      default: xw_next = '0;
    endcase

    mag = xw3[WRAP_W-1] ? WRAP_W'(-xw3) : WRAP_W'(xw3);
    fold_next = (mag > WRAP_W'(ANG_HALF_PI)) ? MAG_W'(WRAP_W'(ANG_PI) - mag) : MAG_W'(mag);

    idx_prod = IDX_PROD_W'(m4) * IDX_PROD_W'(IDX_RECIP);

    idx_fix = (rem6 >= SEGP_W'(ANG_HALF_PI)) ? (est6 + 1'b1) : est6;

    rounded = sum9 + (SUM_W'(1) << (RSH - 1));
    val_raw = rounded[SUM_W-1:RSH];
    if (quarter9 || (val_raw > VAL_W'(ONE_Q16))) begin
      val_mag = ONE_Q16;
    end else begin
      val_mag = VALUE_W'(val_raw);
    end
    value_next = neg9 ? $signed(-val_mag) : $signed(val_mag);
  end

  always_ff @(posedge clk) begin
    v1 <= in_item.v;
    x1 <= in_item.x;
    cls1 <= in_item.cls;
    q1 <= wrap_prod[WRAP_SHIFT +: QUOT_W];

    r2 <= r_full[WRAP_W-1:0];
    x2 <= x1;
    cls2 <= cls1;

    xw3 <= xw_next;

    neg4 <= xw3[WRAP_W-1];
    m4 <= fold_next;
    quarter4 <= (fold_next == MAG_W'(ANG_HALF_PI));

    est5 <= idx_prod[IDX_SHIFT +: IW + 1];
    segp5 <= SEGP_W'(m4) * SEGP_W'(TABLE_SEGMENTS);
    neg5 <= neg4;
    m5 <= m4;
    quarter5 <= quarter4;

    rem6 <= segp5 - SEGP_W'(est5) * SEGP_W'(ANG_HALF_PI);
    est6 <= est5;
    neg6 <= neg5;
    m6 <= m5;
    quarter6 <= quarter5;

    idx7 <= (idx_fix > (IW + 1)'(TABLE_SEGMENTS - 1)) ? IW'(TABLE_SEGMENTS - 1)
                                                      : idx_fix[IW-1:0];
    neg7 <= neg6;
    m7 <= m6;
    quarter7 <= quarter6;

    slope8 <= slope_rom[idx7];
    offset8 <= offset_rom[idx7];
    neg8 <= neg7;
    m8 <= m7;
    quarter8 <= quarter7;

    sum9 <= SUM_W'(slope8) * SUM_W'(m8) + (SUM_W'(offset8) << 24);
    neg9 <= neg8;
    quarter9 <= quarter8;

    value <= value_next;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> ##(STAGES - 1) strobe)
    else $error("result did not leave the pipeline on time");
  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (value <= 18'sd65536 && value >= -18'sd65536))
    else $error("result outside plus or minus one");
  a_segment: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (32'(idx7) < 32'(TABLE_SEGMENTS)))
    else $error("segment index past end of table");
`endif

endmodule
`default_nettype wire

// ===== sv/sine_cosine_segment_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted angle goes through the front register, the queue and the back pipeline to strobe
// throughput: one angle per clock; the back pipeline drains one transaction every cycle,
//   so busy stays low in steady operation
// the receiver cannot stall: each result shows for exactly one cycle with strobe
// reset (synchronous, rst high) clears the front hold flag, queue pointers and pipeline valids
module sine_cosine_segment_table
  import scst_pkg::*;
#(
  parameter int TABLE_SEGMENTS = 128,
  parameter int COEFF_WIDTH = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic signed [31:0] angle,
  output logic                    strobe,
  output logic signed [17:0]      value
);

  logic       push;
  logic       q_full;
  logic       q_empty;
  scst_item_t front_item;
  scst_item_t back_item;

  scst_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .angle  (angle),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .item   (front_item)
  );

  scst_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .pop   (!q_empty),
    .dout  (back_item),
    .empty (q_empty),
    .full  (q_full)
  );

  scst_back #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS),
    .COEFF_WIDTH    (COEFF_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_item  (back_item),
    .strobe   (strobe),
    .value    (value)
  );

endmodule
`default_nettype wire

// ===== tb/sine_cosine_segment_table_tb.sv =====
`timescale 1ns / 1ps
module sine_cosine_segment_table_tb;

  localparam int SEGMENTS = 128;
  localparam int SEG_IW = $clog2(SEGMENTS);
  localparam int CW = 18;
  localparam longint ANGLE_PI = 52707179;
  localparam longint ANGLE_HALF = 26353589;
  localparam longint ANGLE_TURN = 105414358;
  localparam logic [63:0] PI_Q2_62 = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] UNIT_Q2_62 = 64'h4000_0000_0000_0000;
  localparam logic [17:0] FULL_SCALE = 18'd65536;
  localparam logic MODE_SINE = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  typedef struct {
    logic              m;
    logic signed [31:0] a;
    logic [17:0]       v;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic signed [31:0] angle = '0;
  logic busy;
  logic strobe;
  logic signed [17:0] value;

  logic [63:0] seg_slope [SEGMENTS];
  logic [63:0] seg_offset [SEGMENTS];
  sample_t expected_values[$];
  int errors = 0;
  int sent_count = 0;
  int checked_count = 0;
  int burst_left = 8;

  sine_cosine_segment_table u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .angle (angle),
    .strobe(strobe),
    .value (value)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // truncated product of two unsigned q2.62 numbers
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, low, high;
    ah = a >> 32;
    al = {32'd0, a[31:0]};
    bh = b >> 32;
    bl = {32'd0, b[31:0]};
    ll = al * bl;
    lh = al * bh;
    hl = ah * bl;
    hh = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    low = {mid[31:0], ll[31:0]};
    high = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (high << 2) | (low >> 62);
  endfunction

  function automatic logic [63:0] round_coeff(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (61 - CW))) >> (62 - CW);
    return (r > ((64'd1 << CW) - 64'd1)) ? ((64'd1 << CW) - 64'd1) : r;
  endfunction

  // slope and offset of the best-fit line of sin over each segment
  task automatic build_segment_table();
    logic [63:0] d, d2, d4, sd, qd, c, c2, s, co, t, u, k, m, mc, n;
    d = PI_Q2_62 / 64'(4 * SEGMENTS);
    d2 = q62_product(d, d);
    d4 = q62_product(d2, d2);
    sd = UNIT_Q2_62 - d2 / 64'd6 + d4 / 64'd120;
    qd = UNIT_Q2_62 - d2 / 64'd10 + d4 / 64'd280;
    for (int i = 0; i < SEGMENTS; i++) begin
      c = d * (64'd2 * 64'(i) + 64'd1);
      c2 = q62_product(c, c);
      s = c;
      co = UNIT_Q2_62;
      t = c;
      u = UNIT_Q2_62;
      for (int j = 1; j <= 16; j++) begin
        n = 64'(j);
        t = q62_product(t, c2) / ((64'd2 * n) * (64'd2 * n + 64'd1));
        u = q62_product(u, c2) / ((64'd2 * n - 64'd1) * (64'd2 * n));
        if (n[0]) begin
          s = s - t;
          co = co - u;
        end else begin
          s = s + t;
          co = co + u;
        end
      end
      k = q62_product(s, sd);
      m = q62_product(co, qd);
      mc = q62_product(m, c);
      seg_slope[i] = round_coeff(m);
      seg_offset[i] = round_coeff((k > mc) ? (k - mc) : 64'd0);
    end
  endtask

  function automatic logic [17:0] predict_value(input logic m, input logic signed [31:0] a);
    longint x, turns;
    logic negative;
    logic [63:0] ux, seg, sum, mag;
    x = longint'(a);
    if (m == MODE_COSINE) x = ANGLE_HALF - x;
    if (x > ANGLE_PI) begin
      turns = (x + ANGLE_PI) / ANGLE_TURN;
      x = x - turns * ANGLE_TURN;
    end else if (x < -ANGLE_PI) begin
      turns = (ANGLE_PI - x) / ANGLE_TURN;
      x = x + turns * ANGLE_TURN;
    end
    negative = (x < 0);
    if (negative) x = -x;
    if (x > ANGLE_HALF) x = ANGLE_PI - x;
    if (x == ANGLE_HALF) begin
      mag = 64'(FULL_SCALE);
    end else begin
      ux = 64'(x);
      seg = (ux * 64'(SEGMENTS)) / 64'(ANGLE_HALF);
      if (seg > 64'(SEGMENTS - 1)) seg = 64'(SEGMENTS - 1);
      sum = seg_slope[seg[SEG_IW-1:0]] * ux + (seg_offset[seg[SEG_IW-1:0]] << 24);
      mag = (sum + (64'd1 << (CW + 7))) >> (CW + 8);
      if (mag > 64'(FULL_SCALE)) mag = 64'(FULL_SCALE);
    end
    return negative ? 18'(64'd0 - mag) : 18'(mag);
  endfunction

  task automatic send_angle(input logic m, input logic signed [31:0] a);
    sample_t item;
    int gap;
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    angle <= a;
    do @(posedge clk); while (busy !== 1'b0);
    item.m = m;
    item.a = a;
    item.v = predict_value(m, a);
    expected_values.push_back(item);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        angle <= $urandom;
        mode <= 1'($urandom_range(0, 1));
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_angle();
    longint a;
    case ($urandom_range(0, 3))
      0: a = longint'($signed($urandom));
      1: a = longint'($urandom_range(0, 32'(4 * ANGLE_TURN))) - 2 * ANGLE_TURN;
      // around multiples of a quarter turn, where folding and wrapping switch
      2: a = (longint'($urandom_range(0, 80)) - 40) * ANGLE_HALF
             + longint'($urandom_range(0, 6)) - 3;
      default: a = (ANGLE_HALF * longint'($urandom_range(0, SEGMENTS))) / SEGMENTS
                   + longint'($urandom_range(0, 2)) - 1;
    endcase
    return 32'(a);
  endfunction

  always @(posedge clk) begin
    sample_t exp_item;
    if (!rst && strobe === 1'b1) begin
      if (expected_values.size() == 0) begin
        $display("%0t unexpected result: expected none, actual value %0d", $time, value);
        errors++;
      end else begin
        exp_item = expected_values.pop_front();
        checked_count++;
        if (value !== exp_item.v) begin
          $display("%0t value mismatch (mode %0d angle %0d): expected %0d, actual %0d",
                   $time, exp_item.m, exp_item.a, $signed(exp_item.v), value);
          errors++;
        end
      end
    end
  end

  task automatic test_sine_corners();
    send_angle(MODE_SINE, 32'sd0);
    send_angle(MODE_SINE, 32'sd1);
    send_angle(MODE_SINE, -32'sd1);
    send_angle(MODE_SINE, 32'(ANGLE_HALF));
    send_angle(MODE_SINE, 32'(-ANGLE_HALF));
    send_angle(MODE_SINE, 32'(ANGLE_HALF - 1));
    send_angle(MODE_SINE, 32'(ANGLE_HALF + 1));
    send_angle(MODE_SINE, 32'(ANGLE_PI));
    send_angle(MODE_SINE, 32'(-ANGLE_PI));
    send_angle(MODE_SINE, 32'(ANGLE_PI + 1));
    send_angle(MODE_SINE, 32'(-ANGLE_PI - 1));
    send_angle(MODE_SINE, 32'sh7FFF_FFFF);
    send_angle(MODE_SINE, 32'sh8000_0000);
    // either side of the first segment boundary
    send_angle(MODE_SINE, 32'sd205887);
    send_angle(MODE_SINE, 32'sd205888);
  endtask

  task automatic test_cosine_corners();
    send_angle(MODE_COSINE, 32'sd0);
    send_angle(MODE_COSINE, 32'(ANGLE_HALF));
    send_angle(MODE_COSINE, 32'(-ANGLE_HALF));
    send_angle(MODE_COSINE, 32'(ANGLE_PI));
    send_angle(MODE_COSINE, 32'(ANGLE_HALF + ANGLE_PI + 1));
    send_angle(MODE_COSINE, 32'sh7FFF_FFFF);
    send_angle(MODE_COSINE, 32'sh8000_0000);
    send_angle(MODE_COSINE, -32'sd1);
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) send_angle(1'($urandom_range(0, 1)), random_angle());
  endtask

  task automatic test_pause_until_drained();
    test_random_stream(20);
    wait_all_results();
    test_random_stream(20);
  endtask

  initial begin
    build_segment_table();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_sine_corners();
    test_cosine_corners();
    test_random_stream(250);
    test_pause_until_drained();
    test_random_stream(235);
    wait_all_results();
    repeat (16) @(posedge clk);
    $display("covered %0d transactions in both modes with bursty start, %0d results checked",
             sent_count, checked_count);
    $display("corner angles, wrap past +/-pi, quarter turns, full 32-bit range, one drain");
    if (errors == 0 && expected_values.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
